### rtl/ubsd_pkg.sv
// shared types and constants for the unicode byte stream decoder
`default_nettype none

package ubsd_pkg;

    // encoding register codes
    localparam logic [2:0] ENC_UTF8     = 3'd0;
    localparam logic [2:0] ENC_UTF16_BE = 3'd1;
    localparam logic [2:0] ENC_UTF16_LE = 3'd2;
    localparam logic [2:0] ENC_UTF32_BE = 3'd3;
    localparam logic [2:0] ENC_UTF32_LE = 3'd4;

    // result status codes
    localparam logic [1:0] ST_CHAR    = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_END     = 2'd2;

    // input mode codes
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_END  = 1'b1;

    // utf-8 lead byte thresholds and continuation mask
    localparam logic [7:0] LEAD6     = 8'hfc;
    localparam logic [7:0] LEAD5     = 8'hf8;
    localparam logic [7:0] LEAD4     = 8'hf0;
    localparam logic [7:0] LEAD3     = 8'he0;
    localparam logic [7:0] LEAD2     = 8'hc0;
    localparam logic [7:0] CONT_MASK = 8'h3f;

    // unit lengths in bytes
    localparam logic [2:0] UNIT16_BYTES = 3'd2;
    localparam logic [2:0] UNIT32_BYTES = 3'd4;

    typedef struct packed {
        logic [2:0]  pend;
        logic [31:0] acc;
    } t_dec_state;

    typedef struct packed {
        logic        emit;
        logic [31:0] code_point;
        logic [1:0]  status;
    } t_dec_result;

endpackage

`default_nettype wire

### rtl/ubsd_step.sv
// single decode step: next decoder state and optional result for one item
`default_nettype none

module ubsd_step
    import ubsd_pkg::*;
(
    input  wire logic [2:0]  i_enc,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_byte,
    input  wire t_dec_state  i_state,
    output t_dec_state       o_state,
    output t_dec_result      o_res
);

    logic [1:0]  idx;
    logic [2:0]  idx_inc;
    logic [2:0]  unit_len;
    logic [31:0] acc_be;
    logic [31:0] acc_le;
    logic [31:0] acc_u8;
    logic [2:0]  pend_dec;

    assign idx      = i_state.pend[1:0];
    assign idx_inc  = {1'b0, idx} + 3'd1;
    assign acc_be   = {i_state.acc[23:0], i_byte};
    assign acc_u8   = {i_state.acc[25:0], i_byte[5:0] & CONT_MASK[5:0]};
    assign pend_dec = i_state.pend - 3'd1;
    assign unit_len = (i_enc == ENC_UTF16_BE || i_enc == ENC_UTF16_LE) ?
                      UNIT16_BYTES : UNIT32_BYTES;

    always_comb begin
        case (idx)
            2'd0:    acc_le = i_state.acc | {24'd0, i_byte};
            2'd1:    acc_le = i_state.acc | {16'd0, i_byte, 8'd0};
            2'd2:    acc_le = i_state.acc | {8'd0, i_byte, 16'd0};
            default: acc_le = i_state.acc | {i_byte, 24'd0};
        endcase
    end

    always_comb begin
        o_state          = i_state;
        o_res.emit       = 1'b0;
        o_res.code_point = '0;
        o_res.status     = ST_CHAR;
        if (i_mode == MODE_END) begin
            o_res.emit   = 1'b1;
            o_res.status = (i_enc == ENC_UTF8 && i_state.pend != 3'd0) ?
                           ST_INVALID : ST_END;
            o_state      = '0;
        end else begin
            case (i_enc)
                ENC_UTF8: begin
                    if (i_state.pend != 3'd0) begin
                        o_state.pend = pend_dec;
                        o_state.acc  = acc_u8;
                        if (pend_dec == 3'd0) begin
                            o_res.emit       = 1'b1;
                            o_res.code_point = acc_u8;
                            o_state.acc      = '0;
                        end
                    end else begin
                        case (i_byte) inside
                            [LEAD6:8'hff]: begin
                                o_state.acc  = {31'd0, i_byte[0]};
                                o_state.pend = 3'd5;
                            end
                            [LEAD5:8'hfb]: begin
                                o_state.acc  = {30'd0, i_byte[1:0]};
                                o_state.pend = 3'd4;
                            end
                            [LEAD4:8'hf7]: begin
                                o_state.acc  = {29'd0, i_byte[2:0]};
                                o_state.pend = 3'd3;
                            end
                            [LEAD3:8'hef]: begin
                                o_state.acc  = {28'd0, i_byte[3:0]};
                                o_state.pend = 3'd2;
                            end
                            [LEAD2:8'hdf]: begin
                                o_state.acc  = {27'd0, i_byte[4:0]};
                                o_state.pend = 3'd1;
                            end
                            default: begin
                                o_res.emit       = 1'b1;
                                o_res.code_point = {24'd0, i_byte};
                            end
                        endcase
                    end
                end
                ENC_UTF16_BE, ENC_UTF16_LE, ENC_UTF32_BE, ENC_UTF32_LE: begin
                    if (idx_inc >= unit_len) begin
                        o_res.emit       = 1'b1;
                        o_res.code_point = (i_enc == ENC_UTF16_BE ||
                                            i_enc == ENC_UTF32_BE) ? acc_be : acc_le;
                        o_state          = '0;
                    end else begin
                        o_state.pend = idx_inc;
                        o_state.acc  = (i_enc == ENC_UTF16_BE ||
                                        i_enc == ENC_UTF32_BE) ? acc_be : acc_le;
                    end
                end
                default: begin
                    // unused encoding: flag the byte, keep state
                    o_res.emit   = 1'b1;
                    o_res.status = ST_INVALID;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/unicode_byte_stream_decoder.sv
// top level of the unicode byte stream decoder: input register, decode step, result register
`default_nettype none

// Decodes a byte stream into code points, one byte (or end marker) per transfer.
// Encodings: utf-8 in its original up-to-six-byte form, utf-16 big/little endian
// as raw 16-bit units, utf-32 big/little endian. One byte is taken every cycle
// for as long as the output side keeps up; the output stall reaches the input
// stall in the same cycle, so only a held result slows the input. A result
// passes through the input register, then one decode step into the result
// register; a held result can delay that step. Bytes that only extend a sequence
// give no result. The end marker always gives one result: end, or invalid for
// an unfinished utf-8 sequence. The encoding register is written only with no
// input byte held; a write discards any partial sequence.

module unicode_byte_stream_decoder
    import ubsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_in_byte,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_code_point,
    output logic [1:0]       o_status,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_encoding
);

    // control registers
    logic        r_a_vld;
    logic        r_b_vld;
    logic [2:0]  r_enc;
    t_dec_state  r_state;

    // payload registers
    logic        r_mode;
    logic [7:0]  r_byte;
    logic [31:0] r_code_point;
    logic [1:0]  r_status;

    t_dec_state  n_state;
    t_dec_result res;

    logic fire;
    logic a_load;
    logic cfg_acc;

    // the held byte is decoded when the result register is free or being emptied
    assign fire        = r_a_vld && (!r_b_vld || !i_out_stall);
    assign o_in_stall  = r_a_vld && !fire;
    assign a_load      = i_in_valid && !o_in_stall;
    // encoding changes only with nothing held in the input register
    assign o_cfg_ready = !r_a_vld;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    ubsd_step u_step (
        .i_enc   (r_enc),
        .i_mode  (r_mode),
        .i_byte  (r_byte),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_enc   <= ENC_UTF8;
            r_state <= '0;
        end else begin
            // input register occupancy
            if (a_load) begin
                r_a_vld <= 1'b1;
            end else if (fire) begin
                r_a_vld <= 1'b0;
            end
            // result register occupancy, only steps with a result fill it
            if (fire && res.emit) begin
                r_b_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_b_vld <= 1'b0;
            end
            // decoder state, a config write discards any partial sequence
            if (cfg_acc) begin
                r_enc   <= i_encoding;
                r_state <= '0;
            end else if (fire) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_mode <= i_mode;
            r_byte <= i_in_byte;
        end
        if (fire && res.emit) begin
            r_code_point <= res.code_point;
            r_status     <= res.status;
        end
    end

    assign o_out_valid  = r_b_vld;
    assign o_code_point = r_code_point;
    assign o_status     = r_status;

`ifndef ASSERT_OFF
    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pend <= 3'd5)
        else $error("pending count out of range");

    a_unit_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_enc != ENC_UTF8) |-> (r_state.pend <= 3'd3))
        else $error("unit byte index out of range");

    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_acc |=> (r_state.pend == 3'd0 && r_state.acc == 32'd0))
        else $error("config write did not clear decoder state");

    a_zero_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_CHAR) |-> (o_code_point == 32'd0))
        else $error("non-character result carries a code point");
`endif

endmodule

`default_nettype wire

### tb/tb_unicode_byte_stream_decoder.sv
// self-checking testbench for the unicode byte stream decoder
`default_nettype none

module tb_unicode_byte_stream_decoder;
    import ubsd_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int ITEM_TARGET  = 1250;
    localparam int SETTLE_TICKS = 6;
    localparam int HOLD_TICKS   = 400;   // long receiver hold-off
    localparam int HOLD_AFTER   = 300;   // transfers taken before the hold-off starts
    localparam int N_ROWS       = 30;

    // ports
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic        i_mode      = MODE_DATA;
    logic [7:0]  i_in_byte   = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_code_point;
    logic [1:0]  o_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_encoding  = ENC_UTF8;

    // hand-written expectation travelling with the byte on the input channel
    logic        drv_typed = 1'b0;
    logic [31:0] drv_cp    = '0;
    logic [1:0]  drv_st    = ST_CHAR;

    // directed stimulus table: a byte, an end marker or an encoding write
    typedef enum logic [1:0] {ROW_BYTE, ROW_END, ROW_ENC} t_row_kind;
    typedef struct packed {
        t_row_kind   kind;
        logic [7:0]  val;
        logic        typed;
        logic [31:0] cp;
        logic [1:0]  st;
    } t_row;

    t_row dir_rows [0:N_ROWS-1];

    // decoder model state
    logic [2:0]  dec_enc;
    logic [2:0]  dec_pend;
    logic [31:0] dec_acc;

    t_dec_result pending_chars [$];

    int  n_sent      = 0;
    int  n_accepted  = 0;
    int  n_errors    = 0;
    bit  send_quiet  = 1'b0;

    unicode_byte_stream_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_in_byte    (i_in_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_code_point (o_code_point),
        .o_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_encoding   (i_encoding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // an encoding write drops any partial sequence
    function automatic void load_encoding(logic [2:0] enc);
        dec_enc  = enc;
        dec_pend = '0;
        dec_acc  = '0;
    endfunction

    // one byte or end marker through the decoder model
    function automatic t_dec_result decode_step(logic mode, logic [7:0] b);
        t_dec_result r;
        logic [2:0]  idx;
        logic [2:0]  unit_len;
        r = '0;
        r.status = ST_CHAR;
        if (mode == MODE_END) begin
            r.emit   = 1'b1;
            r.status = (dec_enc == ENC_UTF8 && dec_pend != 3'd0) ? ST_INVALID : ST_END;
            dec_pend = '0;
            dec_acc  = '0;
            return r;
        end
        case (dec_enc)
            ENC_UTF8: begin
                if (dec_pend != 3'd0) begin
                    // any byte counts as a continuation here, lead bytes too
                    dec_acc  = {dec_acc[25:0], b[5:0]};
                    dec_pend = dec_pend - 3'd1;
                    if (dec_pend == 3'd0) begin
                        r.emit       = 1'b1;
                        r.code_point = dec_acc;
                        dec_acc      = '0;
                    end
                end else if (b >= LEAD6) begin
                    dec_acc  = 32'(b[0]);
                    dec_pend = 3'd5;
                end else if (b >= LEAD5) begin
                    dec_acc  = 32'(b[1:0]);
                    dec_pend = 3'd4;
                end else if (b >= LEAD4) begin
                    dec_acc  = 32'(b[2:0]);
                    dec_pend = 3'd3;
                end else if (b >= LEAD3) begin
                    dec_acc  = 32'(b[3:0]);
                    dec_pend = 3'd2;
                end else if (b >= LEAD2) begin
                    dec_acc  = 32'(b[4:0]);
                    dec_pend = 3'd1;
                end else begin
                    // below the lead range the byte is its own character
                    r.emit       = 1'b1;
                    r.code_point = 32'(b);
                end
            end
            ENC_UTF16_BE, ENC_UTF16_LE, ENC_UTF32_BE, ENC_UTF32_LE: begin
                unit_len = (dec_enc == ENC_UTF16_BE || dec_enc == ENC_UTF16_LE) ?
                           UNIT16_BYTES : UNIT32_BYTES;
                idx = {1'b0, dec_pend[1:0]};
                if (dec_enc == ENC_UTF16_BE || dec_enc == ENC_UTF32_BE)
                    dec_acc = {dec_acc[23:0], b};
                else
                    dec_acc = dec_acc | (32'(b) << (8 * idx));
                idx = idx + 3'd1;
                if (idx >= unit_len) begin
                    r.emit       = 1'b1;
                    r.code_point = dec_acc;
                    dec_pend     = '0;
                    dec_acc      = '0;
                end else begin
                    dec_pend = idx;
                end
            end
            default: begin
                // unused encodings reject every data byte, state untouched
                r.emit   = 1'b1;
                r.status = ST_INVALID;
            end
        endcase
        return r;
    endfunction

    // transfer monitor: model update on input, comparison on output
    always @(posedge i_clk) begin
        t_dec_result r;
        t_dec_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                load_encoding(i_encoding);
            if (i_in_valid && !o_in_stall) begin
                r = decode_step(i_mode, i_in_byte);
                n_accepted++;
                if (drv_typed) begin
                    r.emit       = 1'b1;
                    r.code_point = drv_cp;
                    r.status     = drv_st;
                end
                if (r.emit)
                    pending_chars.push_back(r);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_chars.size() == 0) begin
                    $error("unexpected result: code_point %h status %0d",
                           o_code_point, o_status);
                    n_errors++;
                end else begin
                    want = pending_chars.pop_front();
                    if (o_code_point !== want.code_point) begin
                        $error("code_point: expected %h, actual %h",
                               want.code_point, o_code_point);
                        n_errors++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        n_errors++;
                    end
                end
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stall runs, quiet stretches, one long hold-off
    initial begin
        int  span;
        bit  quiet;
        bit  held;
        int  stall_left;
        held       = 1'b0;
        stall_left = 0;
        forever begin
            span  = $urandom_range(20, 200);
            quiet = ($urandom_range(0, 3) == 0);
            repeat (span) begin
                @(posedge i_clk);
                if (!held && n_accepted >= HOLD_AFTER) begin
                    // sender keeps offering, so the block fills and stalls its input
                    held = 1'b1;
                    i_out_stall <= 1'b1;
                    repeat (HOLD_TICKS) @(posedge i_clk);
                    stall_left = 0;
                end else if (stall_left > 0) begin
                    i_out_stall <= 1'b1;
                    stall_left--;
                end else begin
                    stall_left = quiet ? 0 : gap_len();
                    i_out_stall <= (stall_left > 0);
                    if (stall_left > 0)
                        stall_left--;
                end
            end
        end
    end

    // one transfer on the byte channel; valid stays high after it
    task automatic put_byte(logic m, logic [7:0] b, logic t, logic [31:0] cp, logic [1:0] st);
        int gap;
        gap = send_quiet ? 0 : gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_in_byte  <= b;
        drv_typed  <= t;
        drv_cp     <= cp;
        drv_st     <= st;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
    endtask

    task automatic put_data(logic [7:0] b);
        put_byte(MODE_DATA, b, 1'b0, '0, ST_CHAR);
    endtask

    task automatic put_end();
        put_byte(MODE_END, 8'($urandom_range(0, 255)), 1'b0, '0, ST_CHAR);
    endtask

    // wait for every result and the block to settle
    task automatic drain();
        @(posedge i_clk);
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // register write, only with the block idle
    task automatic set_encoding(logic [2:0] enc);
        i_in_valid <= 1'b0;
        drain();
        i_cfg_valid <= 1'b1;
        i_encoding  <= enc;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int utf8_len();
        if ($urandom_range(0, 99) < 40)
            return 1;
        return $urandom_range(2, 6);
    endfunction

    function automatic logic [7:0] lead_byte(int len);
        case (len)
            1:       return 8'($urandom_range(8'h00, 8'hbf));
            2:       return 8'($urandom_range(8'hc0, 8'hdf));
            3:       return 8'($urandom_range(8'he0, 8'hef));
            4:       return 8'($urandom_range(8'hf0, 8'hf7));
            5:       return 8'($urandom_range(8'hf8, 8'hfb));
            default: return 8'($urandom_range(8'hfc, 8'hff));
        endcase
    endfunction

    // continuation bytes are mostly proper, sometimes anything at all
    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h80, 8'hbf));
    endfunction

    // utf-8 burst: mostly whole characters, some cut short, some noise
    task automatic utf8_burst(int budget);
        int stop;
        int len;
        int r;
        int k;
        stop = n_sent + budget;
        while (n_sent < stop) begin
            r   = $urandom_range(0, 99);
            len = utf8_len();
            if (r < 80) begin
                put_data(lead_byte(len));
                repeat (len - 1) put_data(cont_byte());
            end else if (r < 90 && len > 1) begin
                put_data(lead_byte(len));
                k = $urandom_range(0, len - 2);
                repeat (k) put_data(cont_byte());
                put_end();
            end else if (r < 94) begin
                put_end();
            end else begin
                put_data(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // raw units and unused encodings: random bytes with the odd end marker
    task automatic raw_burst(int budget);
        int stop;
        stop = n_sent + budget;
        while (n_sent < stop) begin
            if ($urandom_range(0, 99) < 6)
                put_end();
            else
                put_data(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [2:0] enc;
        int         ph;
        int         r;
        int         budget;

        dir_rows = '{
            // pass-through bytes at reset encoding (utf-8)
            '{ROW_BYTE, 8'h00, 1'b1, 32'h0000_0000, ST_CHAR},
            '{ROW_BYTE, 8'hbf, 1'b1, 32'h0000_00bf, ST_CHAR},
            // four-byte sequence
            '{ROW_BYTE, 8'hf0, 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'h9f, 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'h98, 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'h80, 1'b0, '0, ST_CHAR},
            // six-byte sequence with lead-like bytes taken as continuations
            '{ROW_BYTE, 8'hfc, 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'hff, 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'hc0, 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'hff, 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'hff, 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'hff, 1'b0, '0, ST_CHAR},
            // truncated three-byte sequence, then a clean end
            '{ROW_BYTE, 8'he0, 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'h80, 1'b0, '0, ST_CHAR},
            '{ROW_END,  8'hff, 1'b1, 32'h0000_0000, ST_INVALID},
            '{ROW_END,  8'h00, 1'b1, 32'h0000_0000, ST_END},
            // utf-16 big endian, then a half unit dropped at the end marker
            '{ROW_ENC,  8'(ENC_UTF16_BE), 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'h12, 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'h34, 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'h56, 1'b0, '0, ST_CHAR},
            '{ROW_END,  8'h00, 1'b1, 32'h0000_0000, ST_END},
            // utf-32 little endian, then a partial unit wiped by a register write
            '{ROW_ENC,  8'(ENC_UTF32_LE), 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'h01, 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'h02, 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'h03, 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'hff, 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'h77, 1'b0, '0, ST_CHAR},
            // highest unused encoding
            '{ROW_ENC,  8'h07, 1'b0, '0, ST_CHAR},
            '{ROW_BYTE, 8'hff, 1'b1, 32'h0000_0000, ST_INVALID},
            '{ROW_END,  8'h00, 1'b1, 32'h0000_0000, ST_END}
        };

        load_encoding(ENC_UTF8);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < N_ROWS; i++) begin
            case (dir_rows[i].kind)
                ROW_ENC:  set_encoding(dir_rows[i].val[2:0]);
                ROW_END:  put_byte(MODE_END, dir_rows[i].val, dir_rows[i].typed,
                                   dir_rows[i].cp, dir_rows[i].st);
                default:  put_byte(MODE_DATA, dir_rows[i].val, dir_rows[i].typed,
                                   dir_rows[i].cp, dir_rows[i].st);
            endcase
        end

        // random phases, the first eight walking through every encoding code
        ph = 0;
        while (n_sent < ITEM_TARGET) begin
            if (ph < 8) begin
                enc = 3'(ph);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    enc = ENC_UTF8;
                else if (r < 90)
                    enc = 3'($urandom_range(ENC_UTF16_BE, ENC_UTF32_LE));
                else
                    enc = 3'($urandom_range(5, 7));
            end
            set_encoding(enc);
            send_quiet = ($urandom_range(0, 3) == 0);
            budget = (enc > ENC_UTF32_LE) ? $urandom_range(8, 20) : $urandom_range(30, 90);
            if (enc == ENC_UTF8)
                utf8_burst(budget);
            else
                raw_burst(budget);
            ph++;
        end

        i_in_valid <= 1'b0;
        drain();
        if (pending_chars.size() != 0) begin
            $error("%0d results never arrived", pending_chars.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/ubsd_pkg.sv
rtl/ubsd_step.sv
rtl/unicode_byte_stream_decoder.sv
tb/tb_unicode_byte_stream_decoder.sv
